// File: design/r2fft_pkg.sv
// Package for the radix-2 Q15 FFT: word types, field widths and the
// elaboration-time twiddle generator. No dependencies.
`default_nettype none

package r2fft_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int BIN_W     = 17;
    localparam int BIN_NUM_W = 6;
    localparam int Q_FRAC    = 15;
    localparam real PI_APPROX = 3.14159;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } cplx_t;

    // Round to single precision (ties to even), then scale by 2^15 and
    // truncate toward zero.
    function automatic logic signed [SAMPLE_W-1:0] q15_of_real(real x);
        logic [63:0] bits;
        logic [52:0] mant;
        logic [24:0] keep;
        logic [28:0] rest;
        logic [31:0] v;
        logic        neg;
        real         m;
        int          sh;
        neg = (x < 0.0);
        m = neg ? -x : x;
        bits = $realtobits(m);
        if (bits[62:52] == 11'd0) begin
            return '0;
        end
        mant = {1'b1, bits[51:0]};
        keep = {1'b0, mant[52:29]};
        rest = mant[28:0];
        if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && keep[0])) begin
            keep = keep + 25'd1;
        end
        sh = 1031 - int'(bits[62:52]);
        if (sh >= 25) begin
            v = '0;
        end else begin
            v = 32'(keep >> sh);
        end
        return neg ? -v : v;
    endfunction

    // Entry for stage s, index i: cos and sin of -PI_APPROX*i/2^s.
    function automatic cplx_t twiddle_entry(int stage, int idx);
        real   ang;
        cplx_t w;
        int    k;
        ang = PI_APPROX * real'(idx);
        for (k = 0; k < stage; k++) begin
            ang = ang * 0.5;
        end
        w.re = q15_of_real($cos(ang));
        w.im = q15_of_real(-$sin(ang));
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/r2fft_if.sv
// Valid/ready channels of the FFT: sample input and bin output.
// Depends on r2fft_pkg.
`default_nettype none

interface r2fft_in_if import r2fft_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;

    modport source (output valid, output sample_real, output sample_imag, input ready);
    modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface r2fft_out_if import r2fft_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [BIN_W-1:0] bin_real;
    logic signed [BIN_W-1:0] bin_imag;
    logic [BIN_NUM_W-1:0]    bin_number;
    logic                    last_bin;

    modport source (output valid, output bin_real, output bin_imag, output bin_number,
                    output last_bin, input ready);
    modport sink   (input valid, input bin_real, input bin_imag, input bin_number,
                    input last_bin, output ready);
endinterface

`default_nettype wire

// File: design/radix2_fft_q15_fixed.sv
// Top level of the radix-2 decimation-in-time Q15 FFT.
// Depends on r2fft_pkg and the channel interfaces in r2fft_if.
`default_nettype none

// N_POINTS complex Q15 samples are taken one per cycle and stored at
// bit-reversed addresses. After the last one the block runs log2(N_POINTS)
// in-place butterfly stages on one shared complex multiply unit (four 32x32
// multipliers), each butterfly passing through read, two multiply and write
// states, then sends every bin in natural order, each part shifted right by
// 15, with last_bin on the final one. Input ready is low while the stages
// run and while bins go out, so no sample of the next frame is taken until
// the last bin of the current one has been loaded into the output register.
module radix2_fft_q15_fixed
    import r2fft_pkg::*;
#(
    parameter int N_POINTS = 64
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    r2fft_in_if.sink    in_ch,
    r2fft_out_if.source out_ch
);

    localparam int LOG2      = $clog2(N_POINTS);
    localparam int HALF_W    = LOG2 - 1;
    localparam int STG_W     = $clog2(LOG2);
    localparam int ROM_DEPTH = LOG2 * N_POINTS;
    localparam int BFLY_LAST = N_POINTS / 2 - 1;

    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_BF_RD  = 7'b0000010,
        S_BF_M1  = 7'b0000100,
        S_BF_M2  = 7'b0001000,
        S_BF_WR  = 7'b0010000,
        S_EM_RD  = 7'b0100000,
        S_EM_OUT = 7'b1000000
    } state_t;

    state_t              state_reg;
    logic [LOG2-1:0]     cnt_reg;
    logic [STG_W-1:0]    stg_reg;
    logic [HALF_W-1:0]   bfly_reg;
    logic [LOG2-1:0]     bin_reg;
    logic                out_valid_reg;

    cplx_t               store_mem [N_POINTS];
    cplx_t               e_reg;
    cplx_t               o_reg;
    cplx_t               w_lo_reg;
    cplx_t               w_hi_reg;
    logic signed [31:0]  pa_reg, pb_reg, pc_reg, pd_reg;

    logic signed [BIN_W-1:0] bin_real_reg;
    logic signed [BIN_W-1:0] bin_imag_reg;
    logic [BIN_NUM_W-1:0]    bin_number_reg;
    logic                    last_bin_reg;

    cplx_t tw_rom [ROM_DEPTH];

    for (genvar s = 0; s < LOG2; s++) begin : g_tw_stg
        for (genvar i = 0; i < N_POINTS; i++) begin : g_tw
            localparam cplx_t TW = twiddle_entry(s, i);
            assign tw_rom[s * N_POINTS + i] = TW;
        end
    end

    // butterfly addressing: insert a zero at bit position stage
    logic [LOG2-1:0] mid, low_mask, bext, lo_addr, hi_addr, rev_addr, rd_addr;
    always_comb
    begin
        mid      = LOG2'(1) << stg_reg;
        low_mask = mid - LOG2'(1);
        bext     = {1'b0, bfly_reg};
        lo_addr  = (bext & low_mask) | ((bext & ~low_mask) << 1);
        hi_addr  = lo_addr | mid;
        for (int b = 0; b < LOG2; b++)
        begin
            rev_addr[b] = cnt_reg[LOG2-1-b];
        end
        rd_addr = (state_reg == S_EM_RD) ? bin_reg : lo_addr;
    end

    logic in_acc;
    logic out_load;
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == S_EM_OUT) && (!out_valid_reg || out_ch.ready);

    // shared complex multiply: odd word times the selected twiddle
    cplx_t              wsel;
    logic signed [63:0] ma, mb, mc, md;
    cplx_t              bf_sum;
    always_comb
    begin
        wsel = (state_reg == S_BF_M1) ? w_lo_reg : w_hi_reg;
        ma   = 64'(o_reg.re) * 64'(wsel.re);
        mb   = 64'(o_reg.im) * 64'(wsel.im);
        mc   = 64'(o_reg.re) * 64'(wsel.im);
        md   = 64'(o_reg.im) * 64'(wsel.re);
        bf_sum.re = e_reg.re + pa_reg - pb_reg;
        bf_sum.im = e_reg.im + pc_reg + pd_reg;
    end

    logic            wr_en;
    logic [LOG2-1:0] wr_addr;
    cplx_t           wr_data;
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = lo_addr;
        wr_data = bf_sum;
        unique case (state_reg)
            S_LOAD:
            begin
                wr_en      = in_acc;
                wr_addr    = rev_addr;
                wr_data.re = in_ch.sample_real;
                wr_data.im = in_ch.sample_imag;
            end
            S_BF_M2:
            begin
                wr_en = 1'b1;
            end
            S_BF_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_addr;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_BF_RD || state_reg == S_EM_RD)
        begin
            e_reg    <= store_mem[rd_addr];
            o_reg    <= store_mem[hi_addr];
            w_lo_reg <= tw_rom[{stg_reg, lo_addr}];
            w_hi_reg <= tw_rom[{stg_reg, hi_addr}];
        end
        if (state_reg == S_BF_M1 || state_reg == S_BF_M2)
        begin
            pa_reg <= ma[Q_FRAC+31:Q_FRAC];
            pb_reg <= mb[Q_FRAC+31:Q_FRAC];
            pc_reg <= mc[Q_FRAC+31:Q_FRAC];
            pd_reg <= md[Q_FRAC+31:Q_FRAC];
        end
        if (out_load)
        begin
            bin_real_reg   <= e_reg.re[SAMPLE_W-1:Q_FRAC];
            bin_imag_reg   <= e_reg.im[SAMPLE_W-1:Q_FRAC];
            bin_number_reg <= BIN_NUM_W'(bin_reg);
            last_bin_reg   <= (bin_reg == LOG2'(N_POINTS - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            stg_reg       <= '0;
            bfly_reg      <= '0;
            bin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        cnt_reg <= cnt_reg + LOG2'(1);
                        if (cnt_reg == LOG2'(N_POINTS - 1))
                        begin
                            stg_reg   <= '0;
                            bfly_reg  <= '0;
                            state_reg <= S_BF_RD;
                        end
                    end
                end
                S_BF_RD:
                begin
                    state_reg <= S_BF_M1;
                end
                S_BF_M1:
                begin
                    state_reg <= S_BF_M2;
                end
                S_BF_M2:
                begin
                    state_reg <= S_BF_WR;
                end
                S_BF_WR:
                begin
                    bfly_reg <= bfly_reg + HALF_W'(1);
                    if (bfly_reg == HALF_W'(BFLY_LAST))
                    begin
                        if (stg_reg == STG_W'(LOG2 - 1))
                        begin
                            bin_reg   <= '0;
                            state_reg <= S_EM_RD;
                        end
                        else
                        begin
                            stg_reg   <= stg_reg + STG_W'(1);
                            state_reg <= S_BF_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_BF_RD;
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_OUT;
                end
                S_EM_OUT:
                begin
                    if (out_load)
                    begin
                        bin_reg <= bin_reg + LOG2'(1);
                        if (bin_reg == LOG2'(N_POINTS - 1))
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign in_ch.ready       = (state_reg == S_LOAD);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.bin_real   = bin_real_reg;
    assign out_ch.bin_imag   = bin_imag_reg;
    assign out_ch.bin_number = bin_number_reg;
    assign out_ch.last_bin   = last_bin_reg;

endmodule

`default_nettype wire

// File: design/r2fft_chk.sv
// Port-level checker for the FFT top level, bound to it below.
// Depends on r2fft_pkg.
`default_nettype none

module r2fft_chk
    import r2fft_pkg::*;
#(
    parameter int N_POINTS = 64
)(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [BIN_W-1:0] bin_real,
    input wire logic signed [BIN_W-1:0] bin_imag,
    input wire logic [BIN_NUM_W-1:0]    bin_number,
    input wire logic                    last_bin
);

    logic [BIN_NUM_W-1:0] exp_bin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_bin_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_bin_reg <= last_bin ? '0 : exp_bin_reg + BIN_NUM_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_real) && $stable(bin_imag)
            && $stable(bin_number))
        else $error("bin word changed while stalled");

    a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bin_number == exp_bin_reg)
        else $error("bins out of natural order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_bin == (bin_number == BIN_NUM_W'(N_POINTS - 1)))
        else $error("last_bin on wrong bin");

    a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_bin |-> !in_ready)
        else $error("input taken during bin output");

endmodule

bind radix2_fft_q15_fixed r2fft_chk #(.N_POINTS(N_POINTS)) u_r2fft_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .bin_real   (out_ch.bin_real),
    .bin_imag   (out_ch.bin_imag),
    .bin_number (out_ch.bin_number),
    .last_bin   (out_ch.last_bin)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for radix2_fft_q15_fixed: drives sample words, predicts every bin
// with an in-bench fixed-point FFT and compares bin words field by field.
// Depends on r2fft_pkg, the channel interfaces in r2fft_if and the design top level.
module testbench;
    import r2fft_pkg::*;

    localparam int NPTS   = 64;
    localparam int LOG2N  = 6;
    localparam int FRAMES = 2;
    localparam int NDIR   = 24;
    localparam real PI_NUM = 3.14159;

    typedef enum int { MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH } idle_mode_t;

    typedef struct packed {
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic [BIN_NUM_W-1:0]    num;
        logic                    last;
    } bin_word_t;

    logic clk;
    logic rst_n;

    r2fft_in_if  in_ch ();
    r2fft_out_if out_ch ();

    radix2_fft_q15_fixed #(.N_POINTS(NPTS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    logic [31:0] tw_re [LOG2N][NPTS];
    logic [31:0] tw_im [LOG2N][NPTS];
    logic [31:0] st_re [NPTS];
    logic [31:0] st_im [NPTS];
    int          load_idx;

    bin_word_t   bins_due [$];
    idle_mode_t  mode;
    int          errors;
    int          bins_seen;
    int          hold_off;
    bit          hold_done;

    // directed rows: extremes of both parts, then random fill completes the frame
    logic [31:0] dir_re [NDIR] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_8000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_7FFF, 32'h0001_0000,
        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
        32'h0000_0001, 32'h4000_0000, 32'hC000_0000, 32'h0000_0000,
        32'h7FFF_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678
    };
    logic [31:0] dir_im [NDIR] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0000_8000,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_8001, 32'hFFFF_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0000_0000, 32'hC000_0000, 32'h4000_0000, 32'h0000_0001,
        32'h0000_FFFF, 32'h7FFF_0000, 32'h0000_0000, 32'h8765_4321
    };

    // single-precision rounding (ties to even), then Q15 with truncation toward zero
    function automatic logic [31:0] single_q15(real x);
        real    mm;
        real    sc;
        real    fr;
        real    val;
        longint ip;
        int     e;
        int     k;
        bit     neg;
        neg = (x < 0.0);
        mm = neg ? -x : x;
        if (mm == 0.0)
            return 32'h0;
        e = 0;
        while (mm >= 2.0) begin
            mm = mm / 2.0;
            e++;
        end
        while (mm < 1.0) begin
            mm = mm * 2.0;
            e--;
        end
        sc = mm * 8388608.0;
        ip = $rtoi(sc);
        fr = sc - real'(ip);
        if (fr > 0.5 || (fr == 0.5 && ip[0]))
            ip++;
        val = real'(ip);
        for (k = 0; k < e - 8; k++)
            val = val * 2.0;
        for (k = 0; k < 8 - e; k++)
            val = val / 2.0;
        ip = $rtoi(val);
        return neg ? 32'(-ip) : 32'(ip);
    endfunction

    function automatic logic [31:0] q15_mul(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(64'(signed'(a))) * $signed(64'(signed'(b)));
        p = p >>> Q_FRAC;
        return p[31:0];
    endfunction

    task automatic build_twiddles();
        int  s;
        int  i;
        real ang;
        for (s = 0; s < LOG2N; s++)
            for (i = 0; i < NPTS; i++) begin
                ang = PI_NUM * real'(i) / real'(1 << s);
                tw_re[s][i] = single_q15($cos(ang));
                tw_im[s][i] = single_q15(-$sin(ang));
            end
    endtask

    // store one accepted sample; on the last one run the stages and queue all bins
    task automatic fft_take(logic [31:0] re, logic [31:0] im);
        int          a;
        int          b;
        int          hw;
        int          s;
        int          j;
        int          i;
        int          lo;
        int          hi;
        logic [31:0] er, ei, orr, oi;
        bin_word_t   w;
        a = 0;
        for (b = 0; b < LOG2N; b++)
            a[LOG2N-1-b] = load_idx[b];
        st_re[a] = re;
        st_im[a] = im;
        load_idx++;
        if (load_idx < NPTS)
            return;
        load_idx = 0;
        hw = 1;
        for (s = 0; s < LOG2N; s++) begin
            for (j = 0; j < NPTS; j += 2 * hw)
                for (i = j; i < j + hw; i++) begin
                    lo = i;
                    hi = i + hw;
                    er = st_re[lo];
                    ei = st_im[lo];
                    orr = st_re[hi];
                    oi = st_im[hi];
                    st_re[lo] = er + q15_mul(orr, tw_re[s][lo]) - q15_mul(oi, tw_im[s][lo]);
                    st_im[lo] = ei + q15_mul(orr, tw_im[s][lo]) + q15_mul(oi, tw_re[s][lo]);
                    st_re[hi] = er + q15_mul(orr, tw_re[s][hi]) - q15_mul(oi, tw_im[s][hi]);
                    st_im[hi] = ei + q15_mul(orr, tw_im[s][hi]) + q15_mul(oi, tw_re[s][hi]);
                end
            hw = hw * 2;
        end
        for (i = 0; i < NPTS; i++) begin
            w.re = st_re[i][31:15];
            w.im = st_im[i][31:15];
            w.num = BIN_NUM_W'(i);
            w.last = (i == NPTS - 1);
            bins_due.push_back(w);
        end
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2, 3: return 32'($signed($urandom_range(0, 131071)) - 65536);
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 1) ? 32'h0000_8000 : 32'hFFFF_8000;
        endcase
    endfunction

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // sender
    initial
    begin
        int          f;
        int          n;
        int          gap;
        logic [31:0] re, im;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sample_real = '0;
        in_ch.sample_imag = '0;
        out_ch.ready = 1'b0;
        mode = MODE_FREE;
        errors = 0;
        bins_seen = 0;
        hold_off = 0;
        hold_done = 0;
        load_idx = 0;
        build_twiddles();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (f = 0; f < FRAMES; f++) begin
            for (n = 0; n < NPTS; n++) begin
                // each half frame uses the next idle mix
                mode = idle_mode_t'(2 * f + ((n >= NPTS / 2) ? 1 : 0));
                gap = 0;
                if (mode == MODE_SRC_IDLE && $urandom_range(0, 99) < 45)
                    gap = $urandom_range(1, 6);
                if (mode == MODE_BOTH && $urandom_range(0, 99) < 6)
                    gap = $urandom_range(1, 3);
                if (gap > 0) begin
                    in_ch.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                if (f == 0 && n < NDIR) begin
                    re = dir_re[n];
                    im = dir_im[n];
                end else begin
                    re = rand_part();
                    im = rand_part();
                end
                in_ch.sample_real = re;
                in_ch.sample_imag = im;
                in_ch.valid = 1'b1;
                do
                    @(posedge clk);
                while (!in_ch.ready);
                fft_take(re, im);
                @(negedge clk);
            end
        end
        // pause until every queued bin has come back
        in_ch.valid = 1'b0;
        gap = 0;
        while (bins_due.size() != 0 && gap < 200000) begin
            @(negedge clk);
            gap++;
        end
        repeat (50) @(negedge clk);
        $display("Ran %0d transforms of %0d points (extremes, wrap cases, random)", FRAMES, NPTS);
        $display("under four idle/stall mixes with a long output hold; %0d bins checked",
                 bins_seen);
        if (errors == 0 && bins_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver ready; the long hold lands while the next frame's first word waits
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!hold_done && bins_seen == 4) begin
                hold_done <= 1'b1;
                hold_off <= 400;
                out_ch.ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                out_ch.ready <= 1'b0;
            end else if (mode == MODE_SNK_STALL)
                out_ch.ready <= ($urandom_range(0, 99) >= 45);
            else if (mode == MODE_BOTH)
                out_ch.ready <= ($urandom_range(0, 99) >= 6);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // bin checker
    always @(posedge clk)
    begin
        bin_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            bins_seen <= bins_seen + 1;
            if (bins_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected bin word: num %0d", out_ch.bin_number);
            end else begin
                w = bins_due.pop_front();
                if (out_ch.bin_real !== w.re || out_ch.bin_imag !== w.im ||
                    out_ch.bin_number !== w.num || out_ch.last_bin !== w.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"bin mismatch: exp re %0d im %0d num %0d last %0d,",
                                  " got re %0d im %0d num %0d last %0d"},
                                 w.re, w.im, w.num, w.last, out_ch.bin_real,
                                 out_ch.bin_imag, out_ch.bin_number, out_ch.last_bin);
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
